### hdl/qppc_pkg.sv
// Shared constants, types and decode function of the quadrature position P controller.
package qppc_pkg;

    // position count and error widths
    localparam int POS_W      = 32;
    localparam int POS_OUT_W  = 32;
    localparam int TARGET_W   = 32;
    localparam int ERR_W      = POS_W + 1;

    // control and configuration widths
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int DUTY_W     = 9;
    localparam int DZ_W       = 9;
    localparam int DEADBAND_W = 16;
    localparam int ERRCNT_W   = 16;
    localparam int EFFORT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int PWM_TOP    = 400;

    // shared shift-add multiplier
    localparam int MUL_A_W    = ERR_W;
    localparam int MUL_B_W    = GAIN_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int PROD_HI_W  = MUL_P_W - FRAC_W;

    // dead-zone scaling: product of two duty values, divided by PWM_TOP bit by bit
    localparam int SCALE_W    = 2 * DUTY_W;
    localparam int DIV_CNT_W  = $clog2(SCALE_W);

    typedef enum logic [2:0] {
        OP_ENCODER    = 3'd0,
        OP_MOVE       = 3'd1,
        OP_HOLD       = 3'd2,
        OP_SET_COUNT  = 3'd3,
        OP_SET_EFFORT = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_NEG  = 2'd0,
        CFG_GAIN_POS  = 2'd1,
        CFG_DEAD_ZONE = 2'd2,
        CFG_DEADBAND  = 2'd3
    } cfg_idx_t;

    // STEP_DEC lowers the count, STEP_INC raises it
    typedef enum logic [1:0] {
        STEP_NONE    = 2'd0,
        STEP_DEC     = 2'd1,
        STEP_INC     = 2'd2,
        STEP_ILLEGAL = 2'd3
    } step_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;

    // quadrature transition table, previous pair by new pair
    function automatic step_t step_decode(input logic [1:0] prev, input logic [1:0] cur);
        step_t s;
        case ({prev, cur})
            4'b0000, 4'b0101, 4'b1010, 4'b1111: s = STEP_NONE;
            4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_INC;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_DEC;
            default:                            s = STEP_ILLEGAL;
        endcase
        return s;
    endfunction

endpackage

### hdl/qppc_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, stops when no set bits remain.
module qppc_mul
    import qppc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_A_W-1:0] mul_a,
    input  logic [MUL_B_W-1:0] mul_b,
    output mul_sts_t           sts,
    output logic [MUL_P_W-1:0] prod
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MUL_P_W-1:0] acc_reg, acc_next;
    logic [MUL_P_W-1:0] mcand_reg, mcand_next;
    logic [MUL_B_W-1:0] mplier_reg, mplier_next;

    // one partial product per cycle
    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start) begin
            busy_next   = 1'b1;
            acc_next    = '0;
            mcand_next  = MUL_P_W'(mul_a);
            mplier_next = mul_b;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[MUL_P_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MUL_B_W-1:1]};
            if (mplier_next == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign sts  = '{busy: busy_reg, done: done_reg};
    assign prod = acc_reg;

endmodule

### hdl/quadrature_position_p_controller_core.sv
// Quadrature position counter with proportional position control, top level.
//
// Requests enter on the s_ channel (valid/ready); each one yields exactly one
// result on the m_ channel, held in an output register until taken.
// Encoder samples, set count, set effort, unused codes and move requests that
// land inside the deadband finish in the idle state: the result is registered
// and valid on the cycle after acceptance. Hold requests run the shift-add
// multiplier over the gain bits, which stops when no set bits remain. Other
// move requests add a second multiply of the saturated duty by the dead-zone
// scale and a restoring divide by the PWM top, one quotient bit per cycle.
// One request is worked on at a time.
// A new request is taken only in idle with the output register free or being
// drained in that cycle; a stalled receiver therefore holds off the input.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
// Synchronous active-low reset clears position, error count, duty, direction,
// the output register, and loads the default gains, dead zone and deadband.
module quadrature_position_p_controller_core
    import qppc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    // request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_operation,
    input  logic [1:0]                  s_encoder_phases,
    input  logic signed [TARGET_W-1:0]  s_target,
    input  logic signed [TARGET_W-1:0]  s_new_count,
    input  logic signed [EFFORT_W-1:0]  s_effort,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [POS_OUT_W-1:0] m_position,
    output logic [ERRCNT_W-1:0]         m_illegal_transitions,
    output logic [DUTY_W-1:0]           m_duty,
    output logic                        m_reverse,
    output logic                        m_reached
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL1 = 4'b0010,
        S_MUL2 = 4'b0100,
        S_DIV  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [ERRCNT_W-1:0]     errcnt_reg, errcnt_next;
    logic [1:0]              last_ph_reg, last_ph_next;
    logic [DUTY_W-1:0]       duty_reg, duty_next;
    logic                    dir_reg, dir_next;
    logic                    reached_reg, reached_next;
    logic                    m_valid_reg, m_valid_next;

    logic [GAIN_W-1:0]       gain_neg_reg, gain_pos_reg;
    logic [DZ_W-1:0]         dead_zone_reg;
    logic [DEADBAND_W-1:0]   deadband_reg;

    // working registers of a move or hold request
    logic                    hold_reg, hold_next;
    logic                    neg_reg, neg_next;
    logic                    dir_w_reg, dir_w_next;
    logic [SCALE_W-1:0]      quo_reg, quo_next;
    logic [DUTY_W-1:0]       rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;

    logic                    s_accept;
    op_t                     op;
    step_t                   step;

    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        err_u;
    logic                    err_neg;
    logic [ERR_W-1:0]        emag;
    logic                    inband;
    logic [GAIN_W-1:0]       gain_sel;

    logic [EFFORT_W:0]       eff_mag;
    logic [DUTY_W-1:0]       eff_sat;

    logic                    mul_start;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    mul_sts_t                mul_sts;
    logic [MUL_P_W-1:0]      mul_prod;

    logic [PROD_HI_W-1:0]    prod_hi;
    logic                    prod_neg;
    logic [DUTY_W-1:0]       prod_sat;
    logic [DZ_W-1:0]         dz_eff;
    logic [DUTY_W-1:0]       scale_b;

    logic [DUTY_W:0]         rem_t;
    logic                    div_ge;
    logic [DUTY_W-1:0]       div_rem;
    logic [SCALE_W-1:0]      div_quo;
    logic [DUTY_W:0]         duty_sum;
    logic [DUTY_W-1:0]       duty_comp;

    assign s_accept = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign op       = op_t'(s_operation);
    assign step     = step_decode(last_ph_reg, s_encoder_phases);

    // position error and its magnitude
    assign err      = $signed(ERR_W'($signed(pos_reg))) - $signed(ERR_W'(s_target));
    assign err_u    = err;
    assign err_neg  = err[ERR_W-1];
    assign emag     = err_neg ? (~err_u + ERR_W'(1)) : err_u;
    assign inband   = emag < ERR_W'(deadband_reg);
    assign gain_sel = (op == OP_HOLD || s_target[TARGET_W-1]) ? gain_neg_reg : gain_pos_reg;

    // direct effort magnitude, clamped to the PWM top
    assign eff_mag  = s_effort[EFFORT_W-1] ? ((EFFORT_W+1)'(1) << EFFORT_W) - {1'b0, s_effort}
                                           : {1'b0, s_effort};
    assign eff_sat  = (eff_mag > (EFFORT_W+1)'(PWM_TOP)) ? DUTY_W'(PWM_TOP)
                                                         : eff_mag[DUTY_W-1:0];

    // gain product after dropping the Q8.8 fraction
    assign prod_hi  = mul_prod[MUL_P_W-1:FRAC_W];
    assign prod_neg = neg_reg && (prod_hi != '0);
    assign prod_sat = (prod_hi > PROD_HI_W'(PWM_TOP)) ? DUTY_W'(PWM_TOP)
                                                      : prod_hi[DUTY_W-1:0];
    assign dz_eff   = (dead_zone_reg > DZ_W'(PWM_TOP)) ? DZ_W'(PWM_TOP) : dead_zone_reg;
    assign scale_b  = DUTY_W'(PWM_TOP) - DUTY_W'(dz_eff);

    // restoring divide by the PWM top, one quotient bit per step
    assign rem_t    = {rem_reg, quo_reg[SCALE_W-1]};
    assign div_ge   = rem_t >= (DUTY_W+1)'(PWM_TOP);
    assign div_rem  = div_ge ? DUTY_W'(rem_t - (DUTY_W+1)'(PWM_TOP)) : rem_t[DUTY_W-1:0];
    assign div_quo  = {quo_reg[SCALE_W-2:0], div_ge};
    assign duty_sum = {1'b0, div_quo[DUTY_W-1:0]} + (DUTY_W+1)'(dz_eff);
    assign duty_comp = (duty_sum > (DUTY_W+1)'(PWM_TOP)) ? DUTY_W'(PWM_TOP)
                                                         : duty_sum[DUTY_W-1:0];

    qppc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .sts     (mul_sts),
        .prod    (mul_prod)
    );

    // request sequencer
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        errcnt_next  = errcnt_reg;
        last_ph_next = last_ph_reg;
        duty_next    = duty_reg;
        dir_next     = dir_reg;
        reached_next = reached_reg;
        m_valid_next = m_valid_reg;
        hold_next    = hold_reg;
        neg_next     = neg_reg;
        dir_w_next   = dir_w_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        mul_start    = 1'b0;
        mul_a        = emag;
        mul_b        = gain_sel;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    reached_next = 1'b0;
                    case (op)
                        OP_ENCODER: begin
                            case (step)
                                STEP_DEC:     pos_next = pos_reg - POS_W'(1);
                                STEP_INC:     pos_next = pos_reg + POS_W'(1);
                                STEP_ILLEGAL: errcnt_next = errcnt_reg + ERRCNT_W'(1);
                                default:      ;
                            endcase
                            last_ph_next = s_encoder_phases;
                            m_valid_next = 1'b1;
                        end
                        OP_MOVE, OP_HOLD: begin
                            if (op == OP_MOVE && inband) begin
                                // target reached: stop the motor
                                duty_next    = '0;
                                dir_next     = 1'b0;
                                reached_next = 1'b1;
                                m_valid_next = 1'b1;
                            end else begin
                                mul_start  = 1'b1;
                                hold_next  = (op == OP_HOLD);
                                neg_next   = err_neg;
                                state_next = S_MUL1;
                            end
                        end
                        OP_SET_COUNT: begin
                            pos_next     = POS_W'(s_new_count);
                            m_valid_next = 1'b1;
                        end
                        OP_SET_EFFORT: begin
                            dir_next     = s_effort[EFFORT_W-1];
                            duty_next    = eff_sat;
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL1: begin
                if (mul_sts.done) begin
                    if (hold_reg) begin
                        duty_next    = prod_sat;
                        dir_next     = prod_neg;
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        // scale by (top - dead zone) before the divide
                        dir_w_next = prod_neg;
                        mul_start  = 1'b1;
                        mul_a      = MUL_A_W'(prod_sat);
                        mul_b      = MUL_B_W'(scale_b);
                        state_next = S_MUL2;
                    end
                end
            end
            S_MUL2: begin
                if (mul_sts.done) begin
                    quo_next     = mul_prod[SCALE_W-1:0];
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                quo_next     = div_quo;
                rem_next     = div_rem;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(SCALE_W - 1)) begin
                    duty_next    = duty_comp;
                    dir_next     = dir_w_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            errcnt_reg    <= '0;
            last_ph_reg   <= '0;
            duty_reg      <= '0;
            dir_reg       <= 1'b0;
            reached_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            gain_neg_reg  <= GAIN_W'(256);
            gain_pos_reg  <= GAIN_W'(256);
            dead_zone_reg <= '0;
            deadband_reg  <= DEADBAND_W'(10);
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            errcnt_reg  <= errcnt_next;
            last_ph_reg <= last_ph_next;
            duty_reg    <= duty_next;
            dir_reg     <= dir_next;
            reached_reg <= reached_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GAIN_NEG:  gain_neg_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_GAIN_POS:  gain_pos_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_DEAD_ZONE: dead_zone_reg <= cfg_data[DZ_W-1:0];
                    CFG_DEADBAND:  deadband_reg  <= cfg_data[DEADBAND_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        hold_reg    <= hold_next;
        neg_reg     <= neg_next;
        dir_w_reg   <= dir_w_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
    end

    assign m_valid               = m_valid_reg;
    assign m_position            = pos_reg[POS_OUT_W-1:0];
    assign m_illegal_transitions = errcnt_reg;
    assign m_duty                = duty_reg;
    assign m_reverse             = dir_reg;
    assign m_reached             = reached_reg;

    // a request in flight never overlaps a pending result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !m_valid_reg)
        else $error("result pending while a request is in flight");

    // duty never exceeds the PWM top
    assert property (@(posedge aclk) disable iff (!aresetn)
        duty_reg <= DUTY_W'(PWM_TOP))
        else $error("duty above PWM top");

    // a reached move leaves the motor stopped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && reached_reg) |-> (duty_reg == '0 && !dir_reg))
        else $error("reached with nonzero drive");

    // multiplier completions only where the sequencer waits for them
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_sts.done |-> (state_reg == S_MUL1 || state_reg == S_MUL2))
        else $error("multiplier done outside a multiply state");

    // a started multiply is running or finished on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |=> (mul_sts.busy || mul_sts.done))
        else $error("multiplier did not start");

endmodule

### tb/quadrature_position_p_controller_core_test.sv
// Self-checking testbench of the quadrature position P controller core.
module quadrature_position_p_controller_core_test;
    import qppc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int          TAIL_CYCLES = 60;
    localparam int          LONG_HOLD   = 400;
    localparam int          PHASES      = 7;
    localparam int          PHASE_ITEMS = 150;

    // operation codes the block ignores
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]                 op;
        logic [1:0]                 phases;
        logic signed [TARGET_W-1:0] target;
        logic signed [TARGET_W-1:0] new_count;
        logic signed [EFFORT_W-1:0] effort;
    } request_t;

    typedef struct packed {
        logic signed [POS_OUT_W-1:0] position;
        logic [ERRCNT_W-1:0]         illegal;
        logic [DUTY_W-1:0]           duty;
        logic                        reverse;
        logic                        reached;
    } readout_t;

    // one line of the directed stimulus: a request or a register write
    typedef struct packed {
        logic                  is_cfg;
        logic                  typed;
        request_t              rq;
        readout_t              want;
        cfg_idx_t              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } step_row_t;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic [2:0]                  s_operation      = '0;
    logic [1:0]                  s_encoder_phases = '0;
    logic signed [TARGET_W-1:0]  s_target         = '0;
    logic signed [TARGET_W-1:0]  s_new_count      = '0;
    logic signed [EFFORT_W-1:0]  s_effort         = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic signed [POS_OUT_W-1:0] m_position;
    logic [ERRCNT_W-1:0]         m_illegal_transitions;
    logic [DUTY_W-1:0]           m_duty;
    logic                        m_reverse;
    logic                        m_reached;

    // predictor copy of configuration and state
    logic [GAIN_W-1:0]     cfg_gain_neg  = 16'd256;
    logic [GAIN_W-1:0]     cfg_gain_pos  = 16'd256;
    logic [DZ_W-1:0]       cfg_dead_zone = '0;
    logic [DEADBAND_W-1:0] cfg_deadband  = 16'd10;
    logic [1:0]            enc_phases    = '0;
    logic signed [POS_W-1:0] enc_count   = '0;
    logic [ERRCNT_W-1:0]   enc_errors    = '0;
    logic [DUTY_W-1:0]     drv_duty      = '0;
    logic                  drv_reverse   = 1'b0;

    readout_t    pending_readouts[$];
    step_row_t   directed_rows[$];
    int          mismatches    = 0;
    bit          no_idle       = 1'b0;
    int          rx_hold_cycles = 0;
    int unsigned cycle_count   = 0;

    quadrature_position_p_controller_core u_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_operation           (s_operation),
        .s_encoder_phases      (s_encoder_phases),
        .s_target              (s_target),
        .s_new_count           (s_new_count),
        .s_effort              (s_effort),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_position            (m_position),
        .m_illegal_transitions (m_illegal_transitions),
        .m_duty                (m_duty),
        .m_reverse             (m_reverse),
        .m_reached             (m_reached)
    );

    always #10 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // quadrature phase pair to its position in the 0,1,3,2 sequence
    function automatic logic [1:0] gray_to_bin(input logic [1:0] g);
        return {g[1], g[1] ^ g[0]};
    endfunction

    function automatic logic [1:0] bin_to_gray(input logic [1:0] b);
        return b ^ (b >> 1);
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 6));
    endfunction

    // expected readout of one request; advances the predictor state
    function automatic readout_t predict_readout(input request_t rq);
        readout_t   r;
        logic [1:0] delta;
        longint     err;
        longint     emag;
        longint     prod;
        longint     sat;
        longint     dz;
        longint     d;
        logic [GAIN_W-1:0] gain;
        r = '0;
        case (rq.op)
            OP_ENCODER: begin
                // one step forward in the cycle raises the count, back lowers it
                delta = gray_to_bin(rq.phases) - gray_to_bin(enc_phases);
                if (delta == 2'd1)
                    enc_count = enc_count + 1;
                else if (delta == 2'd3)
                    enc_count = enc_count - 1;
                else if (delta == 2'd2)
                    enc_errors = enc_errors + 1'b1;
                enc_phases = rq.phases;
            end
            OP_MOVE, OP_HOLD: begin
                err  = longint'(enc_count) - longint'($signed(rq.target));
                emag = (err < 0) ? -err : err;
                gain = (rq.op == OP_HOLD || $signed(rq.target) < 0) ? cfg_gain_neg
                                                                     : cfg_gain_pos;
                prod = (emag * longint'(gain)) >>> FRAC_W;
                drv_reverse = (err < 0) && (prod != 0);
                sat  = (prod > PWM_TOP) ? PWM_TOP : prod;
                if (rq.op == OP_HOLD) begin
                    drv_duty = sat;
                end else begin
                    // dead-zone compensation, dead zone capped at top
                    dz = (cfg_dead_zone > PWM_TOP) ? PWM_TOP : longint'(cfg_dead_zone);
                    d  = sat * (PWM_TOP - dz) / PWM_TOP + dz;
                    drv_duty = d;
                    if (emag < longint'(cfg_deadband)) begin
                        drv_duty    = '0;
                        drv_reverse = 1'b0;
                        r.reached   = 1'b1;
                    end
                end
            end
            OP_SET_COUNT: begin
                enc_count = rq.new_count;
            end
            OP_SET_EFFORT: begin
                emag = longint'($signed(rq.effort));
                drv_reverse = (emag < 0);
                if (emag < 0)
                    emag = -emag;
                drv_duty = (emag > PWM_TOP) ? PWM_TOP : emag;
            end
            default: begin
            end
        endcase
        r.position = enc_count;
        r.illegal  = enc_errors;
        r.duty     = drv_duty;
        r.reverse  = drv_reverse;
        return r;
    endfunction

    function automatic void report_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    // compare one accepted readout against the oldest pending one
    function automatic void check_readout(input readout_t got);
        readout_t want;
        if (pending_readouts.size() == 0) begin
            report_failure($sformatf("unexpected readout pos=%0d ill=%0d duty=%0d rev=%0d reached=%0d",
                got.position, got.illegal, got.duty, got.reverse, got.reached));
            return;
        end
        want = pending_readouts.pop_front();
        if (got.position !== want.position || got.illegal !== want.illegal ||
            got.duty !== want.duty || got.reverse !== want.reverse ||
            got.reached !== want.reached)
            report_failure($sformatf(
                "mismatch: exp pos=%0d ill=%0d duty=%0d rev=%0d reached=%0d, got pos=%0d ill=%0d duty=%0d rev=%0d reached=%0d",
                want.position, want.illegal, want.duty, want.reverse, want.reached,
                got.position, got.illegal, got.duty, got.reverse, got.reached));
    endfunction

    // random request, mostly legal encoder walks and moves near the position
    function automatic request_t random_request();
        request_t   rq;
        int         pick;
        int         sub;
        int         span;
        logic [1:0] b;
        rq.op        = OP_ENCODER;
        rq.phases    = 2'($urandom);
        rq.target    = $urandom;
        rq.new_count = $urandom;
        rq.effort    = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            sub = $urandom_range(0, 9);
            b   = gray_to_bin(enc_phases);
            if (sub < 4)
                rq.phases = bin_to_gray(b + 2'd1);
            else if (sub < 7)
                rq.phases = bin_to_gray(b - 2'd1);
            else if (sub < 8)
                rq.phases = enc_phases;
            else
                rq.phases = enc_phases ^ 2'b11;
        end else if (pick < 75) begin
            rq.op = (pick < 63) ? OP_MOVE : OP_HOLD;
            sub = $urandom_range(0, 3);
            case (sub)
                1:       span = int'(cfg_deadband) + 2;
                2:       span = 600;
                default: span = 100000;
            endcase
            if (sub != 0)
                rq.target = enc_count + ($urandom_range(0, 2 * span) - span);
        end else if (pick < 83) begin
            rq.op = OP_SET_COUNT;
            sub = $urandom_range(0, 3);
            if (sub == 1)
                rq.new_count = $urandom_range(0, 4000) - 2000;
            else if (sub == 2)
                rq.new_count = 32'h7FFF_FFFF - $urandom_range(0, 3);
            else if (sub == 3)
                rq.new_count = 32'h8000_0000 + $urandom_range(0, 3);
        end else if (pick < 97) begin
            rq.op = OP_SET_EFFORT;
            if ($urandom_range(0, 1) == 1)
                rq.effort = 16'($urandom_range(0, 1000) - 500);
        end else begin
            rq.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        return rq;
    endfunction

    function automatic step_row_t req_row(input logic [2:0] op, input logic [31:0] arg);
        step_row_t row;
        row = '0;
        row.rq.op        = op;
        row.rq.phases    = arg[1:0];
        row.rq.target    = arg;
        row.rq.new_count = arg;
        row.rq.effort    = arg[15:0];
        return row;
    endfunction

    function automatic step_row_t typed_row(input logic [2:0] op, input logic [31:0] arg,
                                            input logic [31:0] pos, input logic [15:0] ill,
                                            input logic [8:0] duty, input logic rev,
                                            input logic reach);
        step_row_t row;
        row = req_row(op, arg);
        row.typed         = 1'b1;
        row.want.position = pos;
        row.want.illegal  = ill;
        row.want.duty     = duty;
        row.want.reverse  = rev;
        row.want.reached  = reach;
        return row;
    endfunction

    function automatic step_row_t cfg_row(input cfg_idx_t idx, input logic [15:0] val);
        step_row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // directed stimulus, default configuration unless a row writes one
    task automatic build_directed_rows();
        directed_rows.push_back(typed_row(OP_ENCODER, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(req_row(OP_ENCODER, 1));
        directed_rows.push_back(req_row(OP_ENCODER, 3));
        directed_rows.push_back(req_row(OP_ENCODER, 2));
        directed_rows.push_back(req_row(OP_ENCODER, 0));
        directed_rows.push_back(req_row(OP_ENCODER, 2));
        // both phases flipping at once
        directed_rows.push_back(req_row(OP_ENCODER, 1));
        directed_rows.push_back(req_row(OP_ENCODER, 2));
        directed_rows.push_back(typed_row(OP_SET_COUNT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2, 0, 0, 0));
        // count wraps from max to min
        directed_rows.push_back(req_row(OP_ENCODER, 0));
        directed_rows.push_back(typed_row(OP_SET_COUNT, 32'h8000_0000, 32'h8000_0000, 2, 0, 0, 0));
        directed_rows.push_back(typed_row(OP_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, 2, 400, 1, 0));
        directed_rows.push_back(typed_row(OP_HOLD, 32'h8000_0000, 32'h8000_0000, 2, 0, 0, 0));
        directed_rows.push_back(typed_row(OP_SET_EFFORT, 32'h8000, 32'h8000_0000, 2, 400, 1, 0));
        directed_rows.push_back(typed_row(OP_SET_EFFORT, 32'h7FFF, 32'h8000_0000, 2, 400, 0, 0));
        directed_rows.push_back(req_row(OP_SET_EFFORT, 32'hFFFF));
        directed_rows.push_back(typed_row(OP_SET_COUNT, 0, 0, 2, 1, 1, 0));
        // just inside and just outside the deadband
        directed_rows.push_back(typed_row(OP_MOVE, 9, 0, 2, 0, 0, 1));
        directed_rows.push_back(req_row(OP_MOVE, 10));
        directed_rows.push_back(req_row(OP_HOLD, -32'sd300));
        directed_rows.push_back(req_row(OP_SPARE_FIRST, 32'h1234_5678));
        // dead zone above top
        directed_rows.push_back(cfg_row(CFG_DEAD_ZONE, 16'd511));
        directed_rows.push_back(req_row(OP_MOVE, 100));
        // zero deadband is never reached
        directed_rows.push_back(cfg_row(CFG_DEADBAND, 16'd0));
        directed_rows.push_back(req_row(OP_MOVE, 0));
        directed_rows.push_back(cfg_row(CFG_GAIN_NEG, 16'd0));
        directed_rows.push_back(req_row(OP_HOLD, 5));
        directed_rows.push_back(cfg_row(CFG_GAIN_POS, 16'hFFFF));
        directed_rows.push_back(req_row(OP_MOVE, 5000));
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_GAIN_NEG:  cfg_gain_neg  = val;
            CFG_GAIN_POS:  cfg_gain_pos  = val;
            CFG_DEAD_ZONE: cfg_dead_zone = val[DZ_W-1:0];
            CFG_DEADBAND:  cfg_deadband  = val;
            default: begin
            end
        endcase
    endtask

    task automatic load_config(input logic [15:0] gneg, input logic [15:0] gpos,
                               input logic [15:0] dz, input logic [15:0] db);
        write_reg(CFG_GAIN_NEG, gneg);
        write_reg(CFG_GAIN_POS, gpos);
        write_reg(CFG_DEAD_ZONE, dz);
        write_reg(CFG_DEADBAND, db);
    endtask

    // wait until every pending readout has been taken
    task automatic drain_readouts();
        while (pending_readouts.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // present one request after a gap and return at the edge it is taken
    task automatic offer_request(input request_t rq, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= rq.op;
        s_encoder_phases <= rq.phases;
        s_target         <= rq.target;
        s_new_count      <= rq.new_count;
        s_effort         <= rq.effort;
        do @(posedge aclk); while (!s_ready);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : readout_sink
        int       gap;
        readout_t got;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.position = m_position;
            got.illegal  = m_illegal_transitions;
            got.duty     = m_duty;
            got.reverse  = m_reverse;
            got.reached  = m_reached;
            check_readout(got);
        end
    end

    // request side
    initial begin : request_source
        step_row_t row;
        request_t  rq;
        readout_t  want;
        int        phase;
        int        k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        build_directed_rows();
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                s_valid <= 1'b0;
                drain_readouts();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                offer_request(row.rq, draw_gap());
                want = predict_readout(row.rq);
                if (row.typed)
                    want = row.want;
                pending_readouts.push_back(want);
            end
        end

        // random phases, each under its own register setting
        for (phase = 0; phase < PHASES; phase++) begin
            s_valid <= 1'b0;
            drain_readouts();
            case (phase)
                0: load_config(16'd256, 16'd256, 16'd0, 16'd10);
                1: load_config(16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)),
                               16'($urandom_range(0, PWM_TOP)), 16'($urandom_range(0, 200)));
                2: load_config(16'hFFFF, 16'hFFFF, 16'(PWM_TOP), 16'hFFFF);
                3: load_config(16'd0, 16'd0, 16'd0, 16'd0);
                4: load_config(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
                               16'd511, 16'd1);
                5: load_config(16'($urandom), 16'($urandom),
                               16'($urandom_range(0, 511)), 16'($urandom));
                default: load_config(16'($urandom_range(64, 2048)),
                                     16'($urandom_range(64, 2048)),
                                     16'($urandom_range(0, 200)),
                                     16'($urandom_range(0, 50)));
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 30 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                // long result stall while requests keep coming
                if (phase == 1 && k == 20)
                    rx_hold_cycles = LONG_HOLD;
                // sender pause until the block has emptied
                if (phase == 3 && k == 75) begin
                    s_valid <= 1'b0;
                    drain_readouts();
                end
                rq = random_request();
                offer_request(rq, draw_gap());
                pending_readouts.push_back(predict_readout(rq));
            end
        end

        s_valid <= 1'b0;
        drain_readouts();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_readouts.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
